FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/gcne_pkg.sv
// Types, constants and the neighbor order table of the grid cell neighbor enumerator.
package gcne_pkg;

    localparam int INDEX_W     = 31;
    localparam int COORD_OUT_W = 10;
    localparam int CFG_REG_W   = 11;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int NUM_SLOTS   = 27;
    localparam int SLOT_W      = 5;
    localparam int PLANE_SLOTS = 9;
    localparam int JOB_Q_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_SIZE_I = 2'd0,
        REG_SIZE_J = 2'd1,
        REG_SIZE_K = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_PLANE,
        FR_TOTAL,
        FR_RANGE,
        FR_DIVK,
        FR_DIVI,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        OFF_ZERO,
        OFF_DEC,
        OFF_INC
    } t_off;

    typedef struct packed {
        t_off di;
        t_off dj;
        t_off dk;
    } t_slot_off;

    // Which steps away from the center stay inside the grid.
    typedef struct packed {
        logic dec_i;
        logic inc_i;
        logic dec_j;
        logic inc_j;
        logic dec_k;
        logic inc_k;
    } t_nbr_flags;

    function automatic t_slot_off mk_off(t_off di, t_off dj, t_off dk);
        t_slot_off o;
        o.di = di;
        o.dj = dj;
        o.dk = dk;
        return o;
    endfunction

    // Center plane: center, k+1, k-1, the j+1 group, the j-1 group.
    function automatic t_slot_off center_offset(logic [3:0] sub);
        t_slot_off o;
        unique case (sub)
            4'd0:    o = mk_off(OFF_ZERO, OFF_ZERO, OFF_ZERO);
            4'd1:    o = mk_off(OFF_ZERO, OFF_ZERO, OFF_INC);
            4'd2:    o = mk_off(OFF_ZERO, OFF_ZERO, OFF_DEC);
            4'd3:    o = mk_off(OFF_ZERO, OFF_INC, OFF_ZERO);
            4'd4:    o = mk_off(OFF_ZERO, OFF_INC, OFF_DEC);
            4'd5:    o = mk_off(OFF_ZERO, OFF_INC, OFF_INC);
            4'd6:    o = mk_off(OFF_ZERO, OFF_DEC, OFF_ZERO);
            4'd7:    o = mk_off(OFF_ZERO, OFF_DEC, OFF_DEC);
            4'd8:    o = mk_off(OFF_ZERO, OFF_DEC, OFF_INC);
            default: o = mk_off(OFF_ZERO, OFF_ZERO, OFF_ZERO);
        endcase
        return o;
    endfunction

    // Side planes i-1 and i+1 walk their nine cells in another order.
    function automatic t_slot_off side_offset(logic [3:0] sub, t_off di);
        t_slot_off o;
        unique case (sub)
            4'd0:    o = mk_off(di, OFF_ZERO, OFF_ZERO);
            4'd1:    o = mk_off(di, OFF_DEC, OFF_ZERO);
            4'd2:    o = mk_off(di, OFF_DEC, OFF_DEC);
            4'd3:    o = mk_off(di, OFF_DEC, OFF_INC);
            4'd4:    o = mk_off(di, OFF_ZERO, OFF_DEC);
            4'd5:    o = mk_off(di, OFF_INC, OFF_ZERO);
            4'd6:    o = mk_off(di, OFF_INC, OFF_DEC);
            4'd7:    o = mk_off(di, OFF_INC, OFF_INC);
            4'd8:    o = mk_off(di, OFF_ZERO, OFF_INC);
            default: o = mk_off(di, OFF_ZERO, OFF_ZERO);
        endcase
        return o;
    endfunction

    function automatic t_slot_off slot_offset(logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] sub;
        t_slot_off         o;
        sub = '0;
        priority if (slot < SLOT_W'(PLANE_SLOTS)) begin
            o = center_offset(slot[3:0]);
        end else if (slot < SLOT_W'(2 * PLANE_SLOTS)) begin
            sub = slot - SLOT_W'(PLANE_SLOTS);
            o   = side_offset(sub[3:0], OFF_DEC);
        end else begin
            sub = slot - SLOT_W'(2 * PLANE_SLOTS);
            o   = side_offset(sub[3:0], OFF_INC);
        end
        return o;
    endfunction

    function automatic logic axis_ok(t_off o, logic dec_ok, logic inc_ok);
        logic r;
        unique case (o)
            OFF_DEC: r = dec_ok;
            OFF_INC: r = inc_ok;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic slot_allowed(t_slot_off o, t_nbr_flags f);
        return axis_ok(o.di, f.dec_i, f.inc_i) &
               axis_ok(o.dj, f.dec_j, f.inc_j) &
               axis_ok(o.dk, f.dec_k, f.inc_k);
    endfunction

endpackage

FILE: src/gcne_if.sv
// Request and result channel interfaces.
interface gcne_req_if;
    logic                         valid;
    logic                         ready;
    logic [gcne_pkg::INDEX_W-1:0] cell_index;

    modport source (output valid, output cell_index, input ready);
    modport sink   (input valid, input cell_index, output ready);
endinterface

interface gcne_res_if;
    logic                             valid;
    logic                             ready;
    logic [gcne_pkg::COORD_OUT_W-1:0] cell_i;
    logic [gcne_pkg::COORD_OUT_W-1:0] cell_j;
    logic [gcne_pkg::COORD_OUT_W-1:0] cell_k;
    logic                             valid_res;
    logic                             last;

    modport source (output valid, output cell_i, output cell_j, output cell_k,
                    output valid_res, output last, input ready);
    modport sink   (input valid, input cell_i, input cell_j, input cell_k,
                    input valid_res, input last, output ready);
endinterface

FILE: src/gcne_front.sv
// Front end: takes a request, range-checks the index and splits it into i, j, k.
module gcne_front #(
    parameter int MAX_DIM = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gcne_req_if.sink                           i_req,
    input  logic [$clog2(MAX_DIM+1)-1:0]       i_size_i,
    input  logic [$clog2(MAX_DIM+1)-1:0]       i_size_j,
    input  logic [$clog2(MAX_DIM+1)-1:0]       i_size_k,
    output logic                               o_job_valid,
    input  logic                               i_job_ready,
    output logic                               o_job_ok,
    output gcne_pkg::t_nbr_flags               o_job_flags,
    output logic [$clog2(MAX_DIM)-1:0]         o_job_i,
    output logic [$clog2(MAX_DIM)-1:0]         o_job_j,
    output logic [$clog2(MAX_DIM)-1:0]         o_job_k
);
    import gcne_pkg::*;

    localparam int CW   = $clog2(MAX_DIM);
    localparam int SW   = $clog2(MAX_DIM + 1);
    localparam int PW   = 2 * SW;
    localparam int TW   = 3 * SW;
    localparam int CMPW = (TW > INDEX_W) ? TW : INDEX_W;
    localparam int DW   = ((PW + CW) > INDEX_W) ? (PW + CW) : INDEX_W;
    localparam int CNTW = (CW > 1) ? $clog2(CW) : 1;

    t_front_state        r_state, n_state;
    logic                r_in_full;
    logic [INDEX_W-1:0]  r_in_idx;
    logic [PW-1:0]       r_plane;
    logic [TW-1:0]       r_total;
    logic [INDEX_W-1:0]  r_rem;
    logic [DW-1:0]       r_div;
    logic [CW-1:0]       r_quot;
    logic [CW-1:0]       r_k;
    logic [CNTW-1:0]     r_cnt;
    logic                r_ok;

    logic                take;
    logic                out_of_range;
    logic                ge;
    logic [INDEX_W-1:0]  rem_step;
    logic [CW-1:0]       quot_step;

    assign i_req.ready = !r_in_full;
    assign take        = (r_state == FR_IDLE) && r_in_full;

    // One restoring shift-subtract step per cycle.
    assign ge        = (DW'(r_rem) >= r_div);
    assign rem_step  = ge ? (r_rem - INDEX_W'(r_div)) : r_rem;
    assign quot_step = (r_quot << 1) | CW'(ge);

    assign out_of_range = (CMPW'(r_rem) >= CMPW'(r_total));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FR_IDLE:  if (r_in_full) n_state = FR_PLANE;
            FR_PLANE: n_state = FR_TOTAL;
            FR_TOTAL: n_state = FR_RANGE;
            FR_RANGE: n_state = out_of_range ? FR_PUSH : FR_DIVK;
            FR_DIVK:  if (r_cnt == '0) n_state = FR_DIVI;
            FR_DIVI:  if (r_cnt == '0) n_state = FR_PUSH;
            FR_PUSH:  if (i_job_ready) n_state = FR_IDLE;
            default:  n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_job_valid       = (r_state == FR_PUSH);
        o_job_ok          = r_ok;
        o_job_i           = r_quot;
        o_job_j           = r_rem[CW-1:0];
        o_job_k           = r_k;
        o_job_flags.dec_i = (r_quot != '0);
        o_job_flags.inc_i = (SW'(r_quot) != (i_size_i - SW'(1)));
        o_job_flags.dec_j = (r_rem[CW-1:0] != '0);
        o_job_flags.inc_j = (SW'(r_rem[CW-1:0]) != (i_size_j - SW'(1)));
        o_job_flags.dec_k = (r_k != '0);
        o_job_flags.inc_k = (SW'(r_k) != (i_size_k - SW'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FR_IDLE;
            r_in_full <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_req.valid && i_req.ready) begin
                r_in_full <= 1'b1;
            end else if (take) begin
                r_in_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_idx <= i_req.cell_index;
        end
        unique case (r_state)
            FR_IDLE: begin
                if (r_in_full) r_rem <= r_in_idx;
            end
            FR_PLANE: r_plane <= PW'(i_size_i) * PW'(i_size_j);
            FR_TOTAL: r_total <= TW'(r_plane) * TW'(i_size_k);
            FR_RANGE: begin
                r_quot <= '0;
                r_cnt  <= CNTW'(CW - 1);
                if (out_of_range) begin
                    // rejected: all coordinates read back as zero
                    r_ok  <= 1'b0;
                    r_k   <= '0;
                    r_rem <= '0;
                end else begin
                    r_ok  <= 1'b1;
                    r_div <= DW'(r_plane) << (CW - 1);
                end
            end
            FR_DIVK: begin
                r_rem <= rem_step;
                if (r_cnt == '0) begin
                    r_k    <= quot_step;
                    r_quot <= '0;
                    r_div  <= DW'(i_size_j) << (CW - 1);
                    r_cnt  <= CNTW'(CW - 1);
                end else begin
                    r_quot <= quot_step;
                    r_div  <= r_div >> 1;
                    r_cnt  <= r_cnt - CNTW'(1);
                end
            end
            FR_DIVI: begin
                r_rem  <= rem_step;
                r_quot <= quot_step;
                r_div  <= r_div >> 1;
                if (r_cnt != '0) r_cnt <= r_cnt - CNTW'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/gcne_queue.sv
// Small register queue between the front and back ends.
module gcne_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_count != CNTW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rdata    = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_wdata;
    end

endmodule

FILE: src/gcne_back.sv
// Back end: walks a job's neighbor order, emits one result per cycle unless stalled.
module gcne_back #(
    parameter int COORD_W = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  logic                 i_job_ok,
    input  gcne_pkg::t_nbr_flags i_job_flags,
    input  logic [COORD_W-1:0]   i_job_i,
    input  logic [COORD_W-1:0]   i_job_j,
    input  logic [COORD_W-1:0]   i_job_k,
    gcne_res_if.source           o_res
);
    import gcne_pkg::*;

    function automatic logic [COORD_W-1:0] apply_off(logic [COORD_W-1:0] b, t_off o);
        logic [COORD_W-1:0] r;
        unique case (o)
            OFF_DEC: r = b - COORD_W'(1);
            OFF_INC: r = b + COORD_W'(1);
            default: r = b;
        endcase
        return r;
    endfunction

    logic                   r_busy;
    logic [NUM_SLOTS-1:0]   r_mask;
    logic                   r_ok;
    logic [COORD_W-1:0]     r_base_i;
    logic [COORD_W-1:0]     r_base_j;
    logic [COORD_W-1:0]     r_base_k;
    logic                   r_out_valid;
    logic [COORD_OUT_W-1:0] r_out_i;
    logic [COORD_OUT_W-1:0] r_out_j;
    logic [COORD_OUT_W-1:0] r_out_k;
    logic                   r_out_vres;
    logic                   r_out_last;

    logic [NUM_SLOTS-1:0]   low_one;
    logic [NUM_SLOTS-1:0]   rest;
    logic [NUM_SLOTS-1:0]   load_mask;
    logic [SLOT_W-1:0]      sel;
    t_slot_off              off;
    logic                   can_emit;
    logic                   finish;
    logic                   load;

    // lowest pending slot is the next one in the fixed order
    assign low_one = r_mask & (~r_mask + NUM_SLOTS'(1));
    assign rest    = r_mask & (r_mask - NUM_SLOTS'(1));

    always_comb begin
        sel = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (low_one[s]) sel = sel | SLOT_W'(s);
        end
    end

    assign off = slot_offset(sel);

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            load_mask[s] = i_job_ok ? slot_allowed(slot_offset(SLOT_W'(s)), i_job_flags)
                                    : (s == 0);
        end
    end

    assign can_emit    = r_busy && (!r_out_valid || o_res.ready);
    assign finish      = can_emit && (rest == '0);
    assign o_job_ready = !r_busy || finish;
    assign load        = i_job_valid && o_job_ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.cell_i    = r_out_i;
    assign o_res.cell_j    = r_out_j;
    assign o_res.cell_k    = r_out_k;
    assign o_res.valid_res = r_out_vres;
    assign o_res.last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (can_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mask   <= load_mask;
            r_ok     <= i_job_ok;
            r_base_i <= i_job_i;
            r_base_j <= i_job_j;
            r_base_k <= i_job_k;
        end else if (can_emit) begin
            r_mask <= rest;
        end
        if (can_emit) begin
            r_out_i    <= COORD_OUT_W'(apply_off(r_base_i, off.di));
            r_out_j    <= COORD_OUT_W'(apply_off(r_base_j, off.dj));
            r_out_k    <= COORD_OUT_W'(apply_off(r_base_k, off.dk));
            r_out_vres <= r_ok;
            r_out_last <= (rest == '0);
        end
    end

endmodule

FILE: src/grid_cell_neighbor_enumerator.sv
// Grid cell neighbor enumerator top level: register port, front end, job queue, back end.
//
// Each request carries a linear cell index (k major, then i, then j) into a 3-D grid
// whose sizes size_i, size_j and size_k sit in APB registers at byte addresses 0x0, 0x4
// and 0x8 (11 bits each, reset 1, values above MAX_DIM are clamped to MAX_DIM). For an
// index inside the grid the block returns the cell itself and then every in-bounds cell
// of its 26-neighborhood in a fixed order (center, k+1, k-1, the j+1 group, the j-1
// group, the i-1 plane, the i+1 plane), 1 to 27 results with last set on the final one.
// An index at or beyond size_i*size_j*size_k, or any request while a size is zero, gets
// a single result with valid_res=0, zero coordinates and last=1. The back end emits one
// result per cycle while the result channel is not stalled. The front end forms the
// plane and grid sizes in two multiply stages, then splits the index by two
// one-bit-per-cycle shift-subtract divisions; a rejected index skips the divisions. A
// two-entry job queue lets the front end work on the next request while the back end
// is still emitting. Sizes are to be written only while the block is idle.
module grid_cell_neighbor_enumerator #(
    parameter int MAX_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gcne_req_if.sink                        i_req,
    gcne_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gcne_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gcne_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gcne_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import gcne_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int SW = $clog2(MAX_DIM + 1);
    localparam int JW = 1 + $bits(t_nbr_flags) + 3 * CW;

    // size registers, raw as written
    logic [CFG_REG_W-1:0] r_size_i;
    logic [CFG_REG_W-1:0] r_size_j;
    logic [CFG_REG_W-1:0] r_size_k;

    // clamped sizes seen by the datapath
    logic [SW-1:0]        eff_i;
    logic [SW-1:0]        eff_j;
    logic [SW-1:0]        eff_k;

    logic                 cfg_wr;
    t_cfg_reg             cfg_sel;

    // front end to queue
    logic                 fq_valid;
    logic                 fq_ready;
    logic                 f_ok;
    t_nbr_flags           f_flags;
    logic [CW-1:0]        f_i;
    logic [CW-1:0]        f_j;
    logic [CW-1:0]        f_k;
    logic [JW-1:0]        fq_data;

    // queue to back end
    logic                 qb_valid;
    logic                 qb_ready;
    logic [JW-1:0]        qb_data;
    logic                 b_ok;
    t_nbr_flags           b_flags;
    logic [CW-1:0]        b_i;
    logic [CW-1:0]        b_j;
    logic [CW-1:0]        b_k;

    // ---------------------------------------------------------------
    // APB register port: write on the access phase, pready tied high
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = t_cfg_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_i <= CFG_REG_W'(1);
            r_size_j <= CFG_REG_W'(1);
            r_size_k <= CFG_REG_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_SIZE_I: r_size_i <= pwdata[CFG_REG_W-1:0];
                REG_SIZE_J: r_size_j <= pwdata[CFG_REG_W-1:0];
                REG_SIZE_K: r_size_k <= pwdata[CFG_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_SIZE_I: prdata = APB_DATA_W'(r_size_i);
            REG_SIZE_J: prdata = APB_DATA_W'(r_size_j);
            REG_SIZE_K: prdata = APB_DATA_W'(r_size_k);
            default:    prdata = '0;
        endcase
    end

    // clamp to MAX_DIM; a zero size passes through and makes every request miss
    assign eff_i = (32'(r_size_i) > 32'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(r_size_i);
    assign eff_j = (32'(r_size_j) > 32'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(r_size_j);
    assign eff_k = (32'(r_size_k) > 32'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(r_size_k);

    // ---------------------------------------------------------------
    // front end: range check and index split
    // ---------------------------------------------------------------
    gcne_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_size_i    (eff_i),
        .i_size_j    (eff_j),
        .i_size_k    (eff_k),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job_ok    (f_ok),
        .o_job_flags (f_flags),
        .o_job_i     (f_i),
        .o_job_j     (f_j),
        .o_job_k     (f_k)
    );

    assign fq_data = {f_ok, f_flags, f_i, f_j, f_k};

    // ---------------------------------------------------------------
    // job queue decouples the divider from the result stream
    // ---------------------------------------------------------------
    gcne_queue #(
        .WIDTH (JW),
        .DEPTH (JOB_Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wdata    (fq_data),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rdata    (qb_data)
    );

    assign {b_ok, b_flags, b_i, b_j, b_k} = qb_data;

    // ---------------------------------------------------------------
    // back end: neighbor walk into the output register
    // ---------------------------------------------------------------
    gcne_back #(
        .COORD_W (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job_ok    (b_ok),
        .i_job_flags (b_flags),
        .i_job_i     (b_i),
        .i_job_j     (b_j),
        .i_job_k     (b_k),
        .o_res       (o_res)
    );

endmodule

FILE: src/gcne_checker.sv
// Port-level checker for the grid cell neighbor enumerator, bound to the top level.
`include "assert_macros.svh"

module gcne_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_res_valid,
    input logic                             i_res_ready,
    input logic [gcne_pkg::COORD_OUT_W-1:0] i_cell_i,
    input logic [gcne_pkg::COORD_OUT_W-1:0] i_cell_j,
    input logic [gcne_pkg::COORD_OUT_W-1:0] i_cell_k,
    input logic                             i_valid_res,
    input logic                             i_last
);
    // a stalled result keeps its contents
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable({i_cell_i, i_cell_j, i_cell_k, i_valid_res, i_last}))

    // a rejected request answers with exactly one result
    `ASSERT_IMPLIES(a_reject_last, i_clk, i_rst_n, i_res_valid && !i_valid_res, i_last)

    // a rejected request carries zero coordinates
    `ASSERT_IMPLIES(a_reject_zero, i_clk, i_rst_n, i_res_valid && !i_valid_res, i_cell_i == '0 && i_cell_j == '0 && i_cell_k == '0)

    // reset empties the output register
    `ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_res_valid)

endmodule

bind grid_cell_neighbor_enumerator gcne_checker u_gcne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_cell_i    (o_res.cell_i),
    .i_cell_j    (o_res.cell_j),
    .i_cell_k    (o_res.cell_k),
    .i_valid_res (o_res.valid_res),
    .i_last      (o_res.last)
);

FILE: tb/grid_cell_neighbor_enumerator_test.sv
// Self-checking testbench for the grid cell neighbor enumerator: APB setup, request driver, result monitor.
module grid_cell_neighbor_enumerator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gcne_pkg::*;

    localparam int MAX_DIM = 1024;
    // Cycles to let pass after the last result before touching config or ending.
    localparam int SETTLE_CYCLES = 64;
    // Fourth register slot in the address map; nothing lives there.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_OUT_W-1:0] cell_i;
        logic [COORD_OUT_W-1:0] cell_j;
        logic [COORD_OUT_W-1:0] cell_k;
        logic                   valid_res;
        logic                   last;
    } t_cell_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gcne_req_if req_ch ();
    gcne_res_if res_ch ();

    grid_cell_neighbor_enumerator #(
        .MAX_DIM (MAX_DIM)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the size registers, raw 11-bit values as written.
    logic [CFG_REG_W-1:0] grid_size [3];

    // Cell indexes waiting to be sent; head is the one on the bus.
    logic [INDEX_W-1:0] index_queue [$];
    // Neighbor results predicted for accepted requests, oldest first.
    t_cell_result       expected_cells [$];

    int mismatch_count = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 20) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Appends a cell index to the send list.
    function automatic void add_index(input logic [INDEX_W-1:0] idx);
        index_queue = {index_queue, idx};
    endfunction

    // Appends a predicted result to the scoreboard.
    function automatic void expect_result(input t_cell_result r);
        expected_cells = {expected_cells, r};
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Sizes above MAX_DIM behave as MAX_DIM.
    function automatic longint unsigned axis_cells(input logic [CFG_REG_W-1:0] raw);
        return (raw > MAX_DIM) ? longint'(MAX_DIM) : longint'(raw);
    endfunction

    function automatic longint unsigned grid_cells();
        return axis_cells(grid_size[REG_SIZE_I]) * axis_cells(grid_size[REG_SIZE_J]) *
               axis_cells(grid_size[REG_SIZE_K]);
    endfunction

    function automatic void add_cell(ref t_cell_result cells[$],
                                     input longint unsigned ci, cj, ck);
        t_cell_result r;
        r.cell_i    = COORD_OUT_W'(ci);
        r.cell_j    = COORD_OUT_W'(cj);
        r.cell_k    = COORD_OUT_W'(ck);
        r.valid_res = 1'b1;
        r.last      = 1'b0;
        cells = {cells, r};
    endfunction

    // One of the i-1 / i+1 planes: center column, then j-1 row, k-1, j+1 row, k+1.
    function automatic void add_side_plane(ref t_cell_result cells[$],
                                           input longint unsigned ii, cj, ck,
                                           input bit lo_j, hi_j, lo_k, hi_k);
        add_cell(cells, ii, cj, ck);
        if (lo_j) begin
            add_cell(cells, ii, cj - 1, ck);
            if (lo_k) add_cell(cells, ii, cj - 1, ck - 1);
            if (hi_k) add_cell(cells, ii, cj - 1, ck + 1);
        end
        if (lo_k) add_cell(cells, ii, cj, ck - 1);
        if (hi_j) begin
            add_cell(cells, ii, cj + 1, ck);
            if (lo_k) add_cell(cells, ii, cj + 1, ck - 1);
            if (hi_k) add_cell(cells, ii, cj + 1, ck + 1);
        end
        if (hi_k) add_cell(cells, ii, cj, ck + 1);
    endfunction

    // Splits the index into (i, j, k) and queues the cell plus its in-grid neighbors.
    function automatic void enumerate_neighbors(input logic [INDEX_W-1:0] index);
        longint unsigned si, sj, sk, plane, total, ci, cj, ck, rest;
        bit              lo_i, hi_i, lo_j, hi_j, lo_k, hi_k;
        t_cell_result    cells [$];
        t_cell_result    r;
        si    = axis_cells(grid_size[REG_SIZE_I]);
        sj    = axis_cells(grid_size[REG_SIZE_J]);
        sk    = axis_cells(grid_size[REG_SIZE_K]);
        plane = si * sj;
        total = plane * sk;
        // Outside the grid (or empty grid): one rejected result.
        if (total == 0 || longint'(index) >= total) begin
            r           = '0;
            r.last      = 1'b1;
            expect_result(r);
            return;
        end
        ck   = longint'(index) / plane;
        rest = longint'(index) - ck * plane;
        ci   = rest / sj;
        cj   = rest - ci * sj;
        lo_i = (ci != 0);
        hi_i = (ci != si - 1);
        lo_j = (cj != 0);
        hi_j = (cj != sj - 1);
        lo_k = (ck != 0);
        hi_k = (ck != sk - 1);

        add_cell(cells, ci, cj, ck);
        if (hi_k) add_cell(cells, ci, cj, ck + 1);
        if (lo_k) add_cell(cells, ci, cj, ck - 1);
        if (hi_j) begin
            add_cell(cells, ci, cj + 1, ck);
            if (lo_k) add_cell(cells, ci, cj + 1, ck - 1);
            if (hi_k) add_cell(cells, ci, cj + 1, ck + 1);
        end
        if (lo_j) begin
            add_cell(cells, ci, cj - 1, ck);
            if (lo_k) add_cell(cells, ci, cj - 1, ck - 1);
            if (hi_k) add_cell(cells, ci, cj - 1, ck + 1);
        end
        if (lo_i) add_side_plane(cells, ci - 1, cj, ck, lo_j, hi_j, lo_k, hi_k);
        if (hi_i) add_side_plane(cells, ci + 1, cj, ck, lo_j, hi_j, lo_k, hi_k);

        cells[cells.size() - 1].last = 1'b1;
        foreach (cells[n]) expect_result(cells[n]);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, some followed by a random gap.
    // valid is held until the request is taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                // Request taken at this edge: predict with the current sizes.
                enumerate_neighbors(req_ch.cell_index);
                void'(index_queue.pop_front());
            end
            if (gap_left != 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (index_queue.size() != 0) begin
                req_ch.valid      <= 1'b1;
                req_ch.cell_index <= index_queue[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    // About a third of bursts are followed by a gap.
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. ready follows windows of random period, each with a
    // stall of random length at its start (often none).
    // ------------------------------------------------------------------
    int stall_period = 1;
    int stall_len    = 0;
    int stall_pos    = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_cell_result want;
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("unexpected result i=%0d j=%0d k=%0d v=%0b l=%0b",
                        res_ch.cell_i, res_ch.cell_j, res_ch.cell_k,
                        res_ch.valid_res, res_ch.last));
                end else begin
                    want = expected_cells.pop_front();
                    if (res_ch.cell_i !== want.cell_i || res_ch.cell_j !== want.cell_j ||
                        res_ch.cell_k !== want.cell_k || res_ch.valid_res !== want.valid_res ||
                        res_ch.last !== want.last) begin
                        report_mismatch($sformatf(
                            "got i=%0d j=%0d k=%0d v=%0b l=%0b, want i=%0d j=%0d k=%0d v=%0b l=%0b",
                            res_ch.cell_i, res_ch.cell_j, res_ch.cell_k, res_ch.valid_res,
                            res_ch.last, want.cell_i, want.cell_j, want.cell_k,
                            want.valid_res, want.last));
                    end
                end
            end
            if (stall_pos == 0) begin
                stall_period = $urandom_range(1, 10);
                stall_len    = ($urandom_range(0, 2) == 0) ? 0 :
                               $urandom_range(0, stall_period - 1);
            end
            res_ch.ready <= (stall_pos >= stall_len);
            stall_pos = (stall_pos + 1 == stall_period) ? 0 : stall_pos + 1;
        end
    end

    // ------------------------------------------------------------------
    // APB access: setup, then access; pready sampled mid-cycle.
    // Reads are checked against the shadow copy.
    // ------------------------------------------------------------------
    task automatic cfg_access(input logic [1:0] reg_idx, input bit is_write,
                              input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        if (!is_write && reg_idx != REG_UNUSED &&
            prdata[CFG_REG_W-1:0] !== grid_size[reg_idx]) begin
            report_mismatch($sformatf("register %0d reads %0d, want %0d",
                reg_idx, prdata[CFG_REG_W-1:0], grid_size[reg_idx]));
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Only the low 11 bits are kept; writes to the spare slot are dropped.
        if (is_write && reg_idx != REG_UNUSED) grid_size[reg_idx] = data[CFG_REG_W-1:0];
    endtask

    // Writes all three sizes with junk in the upper data bits, then reads them back.
    task automatic set_grid(input logic [CFG_REG_W-1:0] si, sj, sk);
        cfg_access(REG_SIZE_I, 1'b1, {21'($urandom()), si});
        cfg_access(REG_SIZE_J, 1'b1, {21'($urandom()), sj});
        cfg_access(REG_SIZE_K, 1'b1, {21'($urandom()), sk});
        cfg_access(REG_SIZE_I, 1'b0, '0);
        cfg_access(REG_SIZE_J, 1'b0, '0);
        cfg_access(REG_SIZE_K, 1'b0, '0);
    endtask

    // Block is idle once nothing is queued, on the bus, or owed back.
    task automatic wait_idle();
        while (index_queue.size() != 0 || req_ch.valid || expected_cells.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly tiny grids so edges and interiors both show up; some large or clamped.
    function automatic logic [CFG_REG_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return CFG_REG_W'($urandom_range(1, 4));
        if (roll < 75) return CFG_REG_W'($urandom_range(5, 40));
        if (roll < 87) return CFG_REG_W'($urandom_range(41, 2047));
        if (roll < 97) return CFG_REG_W'(1);
        return '0;
    endfunction

    // Mostly in-grid indexes; some just past the end and some fully random.
    function automatic logic [INDEX_W-1:0] pick_index();
        longint unsigned total;
        int unsigned     roll;
        total = grid_cells();
        roll  = $urandom_range(0, 99);
        if (total != 0 && roll < 80) return INDEX_W'($urandom_range(32'(total - 1), 0));
        if (roll < 90) return INDEX_W'(total + $urandom_range(0, 3));
        return INDEX_W'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int n_items;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cell_index = '0;
        res_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        grid_size[REG_SIZE_I] = CFG_REG_W'(1);
        grid_size[REG_SIZE_J] = CFG_REG_W'(1);
        grid_size[REG_SIZE_K] = CFG_REG_W'(1);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes (1x1x1): the only cell, one past it, the largest index.
        add_index(INDEX_W'(0));
        add_index(INDEX_W'(1));
        add_index('1);
        wait_idle();

        // 3x3x3: full 27-cell neighborhood at the center, corners, face centers, one past the end.
        set_grid(CFG_REG_W'(3), CFG_REG_W'(3), CFG_REG_W'(3));
        add_index(INDEX_W'(13));
        add_index(INDEX_W'(0));
        add_index(INDEX_W'(26));
        add_index(INDEX_W'(4));
        add_index(INDEX_W'(22));
        add_index(INDEX_W'(27));
        wait_idle();

        // Largest grid; size_i above the maximum gets clamped.
        set_grid(CFG_REG_W'(2047), CFG_REG_W'(MAX_DIM), CFG_REG_W'(MAX_DIM));
        add_index(INDEX_W'(0));
        add_index(INDEX_W'((1 << 30) - 1));
        add_index(INDEX_W'(1 << 30));
        add_index('1);
        add_index(INDEX_W'((5 << 20) + (7 << 10) + 1023));
        wait_idle();

        // A zero size empties the grid: every request is rejected.
        set_grid(CFG_REG_W'(4), CFG_REG_W'(0), CFG_REG_W'(4));
        add_index(INDEX_W'(0));
        add_index(INDEX_W'(5));
        wait_idle();

        // Write to the spare register slot must not disturb the sizes.
        set_grid(CFG_REG_W'(2), CFG_REG_W'(3), CFG_REG_W'(1));
        cfg_access(REG_UNUSED, 1'b1, 32'hFFFF_FFFF);
        cfg_access(REG_SIZE_I, 1'b0, '0);
        cfg_access(REG_SIZE_J, 1'b0, '0);
        cfg_access(REG_SIZE_K, 1'b0, '0);
        add_index(INDEX_W'(4));
        add_index(INDEX_W'(5));
        add_index(INDEX_W'(6));
        wait_idle();

        // Random phases, each with its own grid.
        for (int phase = 0; phase < 8; phase++) begin
            set_grid(pick_size(), pick_size(), pick_size());
            if ($urandom_range(0, 3) == 0) cfg_access(REG_UNUSED, 1'b1, $urandom());
            n_items = $urandom_range(50, 75);
            repeat (n_items) add_index(pick_index());
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
